### sv/kss_pkg.sv
// kss_pkg: shared types and constants for the kth smallest stream tracker.
// Used by kss_max_scan and kth_smallest_stream_tracker; no dependencies.
`timescale 1ns / 1ps
package kss_pkg;

	localparam int DataW = 32;
	localparam int KthW  = 5;

	typedef struct packed {
		logic signed [DataW-1:0] value;
		logic                    last;
	} kss_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] kth_value;
		logic                    found;
	} kss_result_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} kss_state_t;

endpackage

### sv/kss_ram.sv
// kss_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module kss_ram #(
	parameter int Width = 32,
	parameter int Depth = 16,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/kss_max_scan.sv
// kss_max_scan: walks kept entries 0..k-1 through the RAM read port and
// keeps a running maximum (first index wins ties). Depends on kss_pkg.
`timescale 1ns / 1ps
module kss_max_scan import kss_pkg::*; #(
	parameter int KMax = 16,
	parameter int CntW = $clog2(KMax + 1),
	parameter int AddrW = (KMax > 1) ? $clog2(KMax) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CntW-1:0]         k_use,
	output logic                    rd_en,
	output logic [AddrW-1:0]        rd_addr,
	input  logic [DataW-1:0]        rd_data,
	output logic                    done,
	output logic signed [DataW-1:0] max_val,
	output logic [AddrW-1:0]        max_idx
);

	logic                    active_q;
	logic [CntW-1:0]         issue_q;
	logic                    rd_vld_s1;
	logic [AddrW-1:0]        rd_idx_s1;
	logic signed [DataW-1:0] best_val_q;
	logic [AddrW-1:0]        best_idx_q;
	logic                    take;
	logic [CntW-1:0]         k_last;

	assign rd_en   = active_q && (issue_q < k_use);
	assign rd_addr = issue_q[AddrW-1:0];
	assign k_last  = k_use - CntW'(1);
	assign take    = rd_vld_s1 && ((rd_idx_s1 == '0) || ($signed(rd_data) > best_val_q));
	assign done    = rd_vld_s1 && (CntW'(rd_idx_s1) == k_last);

	// final compare is folded into the outputs so done and max line up
	assign max_val = take ? $signed(rd_data) : best_val_q;
	assign max_idx = take ? rd_idx_s1 : best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (start) begin
				active_q <= 1'b1;
				issue_q  <= '0;
			end else if (done) begin
				active_q <= 1'b0;
			end else if (rd_en) begin
				issue_q <= issue_q + CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (take) begin
			best_val_q <= $signed(rd_data);
			best_idx_q <= rd_idx_s1;
		end
	end

endmodule

### sv/kth_smallest_stream_tracker.sv
// kth_smallest_stream_tracker: top level, keeps the k smallest values of a set.
// Depends on kss_pkg, kss_ram and kss_max_scan.
`timescale 1ns / 1ps
// Streams signed 32-bit values, flagged last on the final value of each set,
// and reports the kth smallest value of the set on the last transfer (found
// low and kth_value zero when the set held fewer than k values). The kept
// values live in a K_MAX-entry RAM; the largest kept value and its index sit
// in registers. While the kept set is filling, and whenever a new value does
// not displace the largest one, an item needs no rescan. An item that replaces
// the largest kept value overwrites that entry and then rescans all k entries
// through the single RAM read port to find the new largest, and the input stalls
// until the rescan is done. kth is 0..31 written through cfg_we/cfg_wdata; 0
// acts as 1 and values above K_MAX act as K_MAX. A write also empties the
// current set. A new item can be accepted in the cycle the previous result
// transfers; while the consumer stalls a pending result, the input stalls too.
module kth_smallest_stream_tracker import kss_pkg::*; #(
	parameter int K_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  kss_item_t         item,
	output logic              result_valid,
	input  logic              result_stall,
	output kss_result_t       result,
	input  logic              cfg_we,
	input  logic [KthW-1:0]   cfg_wdata
);

	localparam int CntW  = $clog2(K_MAX + 1);
	localparam int AddrW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	kss_state_t              state_q, state_d;
	logic [KthW-1:0]         kth_q;
	logic [CntW-1:0]         count_q;
	logic signed [DataW-1:0] max_val_q;
	logic [AddrW-1:0]        max_idx_q;
	logic                    last_pend_q;
	logic                    result_valid_q;
	kss_result_t             result_q;

	logic [CntW-1:0]         k_use;
	logic                    item_xfer;
	logic                    full;
	logic                    grow_max;
	logic                    replace;
	logic                    start_scan;
	logic                    load_direct;
	kss_result_t             direct_res;
	logic signed [DataW-1:0] fill_max;

	logic                    ram_we;
	logic [AddrW-1:0]        ram_waddr;
	logic                    ram_re;
	logic [AddrW-1:0]        ram_raddr;
	logic [DataW-1:0]        ram_rdata;
	logic                    scan_done;
	logic signed [DataW-1:0] scan_max;
	logic [AddrW-1:0]        scan_idx;

	// rank in use: clamp to 1..K_MAX
	always_comb begin
		if (kth_q == '0) begin
			k_use = CntW'(1);
		end else if (32'(kth_q) > K_MAX) begin
			k_use = CntW'(K_MAX);
		end else begin
			k_use = CntW'(kth_q);
		end
	end

	// input stalls during a rescan and while the consumer holds a pending result
	assign item_stall = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign item_xfer  = item_valid && !item_stall;

	assign full     = (count_q == k_use);
	assign grow_max = (count_q == '0) || (item.value > max_val_q);
	assign fill_max = grow_max ? item.value : max_val_q;
	assign replace  = full && (item.value < max_val_q);

	assign start_scan  = item_xfer && replace;
	assign load_direct = item_xfer && item.last && !replace;

	// result for an item that needs no rescan
	always_comb begin
		direct_res = '0;
		if (full) begin
			direct_res.kth_value = max_val_q;
			direct_res.found     = 1'b1;
		end else if ((count_q + CntW'(1)) == k_use) begin
			direct_res.kth_value = fill_max;
			direct_res.found     = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count, rank and the pending-last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kth_q       <= KthW'(1);
			count_q     <= '0;
			last_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				kth_q   <= cfg_wdata;
				count_q <= '0;
			end else if (item_xfer) begin
				if (item.last) begin
					count_q <= '0;
				end else if (!full) begin
					count_q <= count_q + CntW'(1);
				end
			end
			if (start_scan) begin
				last_pend_q <= item.last;
			end else if (scan_done) begin
				last_pend_q <= 1'b0;
			end
		end
	end

	// largest kept value; only meaningful while count_q is nonzero
	always_ff @(posedge clk) begin
		if (item_xfer && !full) begin
			if (grow_max) begin
				max_val_q <= item.value;
				max_idx_q <= count_q[AddrW-1:0];
			end
		end else if (state_q == ST_SCAN && scan_done) begin
			max_val_q <= scan_max;
			max_idx_q <= scan_idx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_direct || (scan_done && last_pend_q)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			result_q <= direct_res;
		end else if (scan_done && last_pend_q) begin
			result_q.kth_value <= scan_max;
			result_q.found     <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// fill writes the next free entry, replace overwrites the largest one
	assign ram_we    = item_xfer && (!full || replace);
	assign ram_waddr = full ? max_idx_q : count_q[AddrW-1:0];

	kss_ram #(
		.Width (DataW),
		.Depth (K_MAX)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	kss_max_scan #(
		.KMax (K_MAX)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_scan),
		.k_use   (k_use),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.done    (scan_done),
		.max_val (scan_max),
		.max_idx (scan_idx)
	);

`ifndef NO_ASSERTIONS
	// no result is ever waiting while a rescan runs
	a_scan_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !result_valid_q)
		else $error("result pending during rescan");

	// kept count never passes the rank in use
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= k_use)
		else $error("kept count above rank");

	// a not-found result carries zero
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.found) |-> (result_q.kth_value == '0))
		else $error("not-found result is nonzero");

	// a rescan only finishes while in the scan state
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == ST_SCAN))
		else $error("rescan done outside scan state");
`endif

endmodule
